FILE: hdl/stbs_pkg.sv
// Package for the sorted-table binary search block.
// Holds field widths, word layout, request codes and the controller state type.
// No dependencies.
`timescale 1ns / 1ps

package stbs_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int DATA_WIDTH_DEF  = 32;

  localparam int CFG_W   = 11;
  localparam int IDX_W   = 10;
  localparam int FIELD_W = 32;
  localparam int POS_W   = 10;

  // in_tdata: write_index, entry_value, search_key from bit 0 up
  localparam int IN_IDX_LSB   = 0;
  localparam int IN_VAL_LSB   = IN_IDX_LSB + IDX_W;
  localparam int IN_KEY_LSB   = IN_VAL_LSB + FIELD_W;
  localparam int IN_USED_W    = IN_KEY_LSB + FIELD_W;
  localparam int IN_TDATA_W   = ((IN_USED_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((POS_W + 7) / 8) * 8;

  typedef enum logic {
    REQ_WRITE  = 1'b0,
    REQ_SEARCH = 1'b1
  } req_type_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

endpackage

FILE: hdl/stbs_mem.sv
// Table memory for the sorted-table binary search block.
// One write port, one read port with registered read data. Uses stbs_pkg.
`timescale 1ns / 1ps

module stbs_mem #(
  parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF,
  parameter int DATA_WIDTH  = stbs_pkg::DATA_WIDTH_DEF,
  localparam int AW = $clog2(TABLE_DEPTH)
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic [DATA_WIDTH-1:0] wr_data,
  input  logic [AW-1:0]         rd_addr,
  output logic [DATA_WIDTH-1:0] rd_data_r
);

  logic [DATA_WIDTH-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

endmodule

FILE: hdl/stbs_ctrl.sv
// Search controller for the sorted-table binary search block.
// Runs the probe sequence against stbs_mem and holds the output register. Uses stbs_pkg.
`timescale 1ns / 1ps

module stbs_ctrl #(
  parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF,
  parameter int DATA_WIDTH  = stbs_pkg::DATA_WIDTH_DEF,
  localparam int AW = $clog2(TABLE_DEPTH)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [stbs_pkg::CFG_W-1:0]    cfg_wr_data,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [stbs_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic                          in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [stbs_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                          out_tuser,
  output logic                          mem_wr_en,
  output logic [AW-1:0]                 mem_wr_addr,
  output logic [DATA_WIDTH-1:0]         mem_wr_data,
  output logic [AW-1:0]                 mem_rd_addr,
  input  logic [DATA_WIDTH-1:0]         mem_rd_data
);

  localparam int CNT_W = AW + 1;

  stbs_pkg::state_t state_r, state_nxt;
  logic [stbs_pkg::CFG_W-1:0]  count_r;
  logic [AW-1:0]               low_r, low_nxt;
  logic [AW-1:0]               high_r, high_nxt;
  logic [AW-1:0]               mid_r, mid_nxt;
  logic [DATA_WIDTH-1:0]       key_r, key_nxt;
  logic                        hit_r, hit_nxt;
  logic                        out_valid_r;
  logic                        out_found_r;
  logic [stbs_pkg::POS_W-1:0]  out_pos_r;

  logic [stbs_pkg::IDX_W-1:0]   in_idx;
  logic [stbs_pkg::FIELD_W-1:0] in_val;
  logic [stbs_pkg::FIELD_W-1:0] in_key;
  logic [63:0]                  val_ext;
  logic [63:0]                  key_ext;
  logic                         in_accept;
  logic                         wr_in_range;
  logic [CNT_W-1:0]             n_sat;
  logic [AW-1:0]                first_high;
  logic [CNT_W-1:0]             sum_up;
  logic [CNT_W-1:0]             sum_dn;
  logic [AW-1:0]                mid_up;
  logic [AW-1:0]                mid_dn;
  logic                         ent_lt;
  logic                         ent_gt;
  logic                         res_take;

  assign in_idx  = in_tdata[stbs_pkg::IN_IDX_LSB +: stbs_pkg::IDX_W];
  assign in_val  = in_tdata[stbs_pkg::IN_VAL_LSB +: stbs_pkg::FIELD_W];
  assign in_key  = in_tdata[stbs_pkg::IN_KEY_LSB +: stbs_pkg::FIELD_W];
  assign val_ext = {{32{in_val[31]}}, in_val};
  assign key_ext = {{32{in_key[31]}}, in_key};

  assign in_tready   = (state_r == stbs_pkg::ST_IDLE);
  assign in_accept   = in_tvalid && in_tready;
  assign wr_in_range = 32'(in_idx) < TABLE_DEPTH;
  assign n_sat       = (32'(count_r) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : CNT_W'(count_r);
  assign first_high  = AW'(n_sat - CNT_W'(1));

  assign mem_wr_en   = in_accept && (in_tuser == stbs_pkg::REQ_WRITE) && wr_in_range;
  assign mem_wr_addr = AW'(32'(in_idx));
  assign mem_wr_data = val_ext[DATA_WIDTH-1:0];

  // candidate next probes, ready before the compare resolves
  assign sum_up = {1'b0, mid_r} + {1'b0, high_r} + CNT_W'(1);
  assign sum_dn = {1'b0, low_r} + {1'b0, mid_r} - CNT_W'(1);
  assign mid_up = sum_up[AW:1];
  assign mid_dn = sum_dn[AW:1];

  assign ent_lt = $signed(mem_rd_data) < $signed(key_r);
  assign ent_gt = $signed(mem_rd_data) > $signed(key_r);

  assign res_take = (state_r == stbs_pkg::ST_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt   = state_r;
    low_nxt     = low_r;
    high_nxt    = high_r;
    mid_nxt     = mid_r;
    key_nxt     = key_r;
    hit_nxt     = hit_r;
    mem_rd_addr = first_high >> 1;
    case (state_r)
      stbs_pkg::ST_IDLE: begin
        if (in_accept && (in_tuser == stbs_pkg::REQ_SEARCH)) begin
          key_nxt  = key_ext[DATA_WIDTH-1:0];
          hit_nxt  = 1'b0;
          low_nxt  = '0;
          high_nxt = first_high;
          mid_nxt  = first_high >> 1;
          if (n_sat == '0) begin
            state_nxt = stbs_pkg::ST_DONE;
          end else begin
            state_nxt = stbs_pkg::ST_CMP;
          end
        end
      end
      stbs_pkg::ST_CMP: begin
        if (ent_lt) begin
          mem_rd_addr = mid_up;
          low_nxt     = mid_r + AW'(1);
          mid_nxt     = mid_up;
          if (mid_r >= high_r) begin
            state_nxt = stbs_pkg::ST_DONE;
          end
        end else if (ent_gt) begin
          mem_rd_addr = mid_dn;
          high_nxt    = mid_r - AW'(1);
          mid_nxt     = mid_dn;
          if (mid_r <= low_r) begin
            state_nxt = stbs_pkg::ST_DONE;
          end
        end else begin
          mem_rd_addr = mid_r;
          hit_nxt     = 1'b1;
          state_nxt   = stbs_pkg::ST_DONE;
        end
      end
      stbs_pkg::ST_DONE: begin
        mem_rd_addr = mid_r;
        if (res_take) begin
          state_nxt = stbs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = stbs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stbs_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        count_r <= cfg_wr_data;
      end
      if (res_take) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    low_r  <= low_nxt;
    high_r <= high_nxt;
    mid_r  <= mid_nxt;
    key_r  <= key_nxt;
    hit_r  <= hit_nxt;
    if (res_take) begin
      out_found_r <= hit_r;
      out_pos_r   <= hit_r ? stbs_pkg::POS_W'(32'(mid_r)) : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = stbs_pkg::OUT_TDATA_W'(out_pos_r);

endmodule

FILE: hdl/sorted_table_binary_search_top.sv
// Sorted-table binary search, top level.
// Usage:
//   Input stream in_*: in_tuser selects the request (0 write entry, 1 search).
//   A write stores entry_value at write_index and gives no result word; an
//   index at or beyond the table depth is dropped. A search runs a binary
//   search over entries 0 .. entry_count-1 and gives one result word on out_*:
//   out_tuser is found, out_tdata holds the position (0 when not found).
//   cfg_wr_en/cfg_wr_data load entry_count; write it only while idle.
// Timing:
//   A write does not stall the input; the next word may follow at once. A search
//   holds in_tready low while it probes the table memory and until its result
//   is taken into the output register, and the result word appears as in_tready
//   returns high. Each probe is one registered read of the table memory with the
//   compare on the returned data.
//   The output register holds a result while out_tready is low; a new word is
//   accepted meanwhile, and a search finishing behind it waits for the slot.
// Reset: synchronous active-low rst_n clears entry_count and the output
//   valid; the table contents are undefined until written.
// Depends on stbs_pkg, stbs_mem and stbs_ctrl.
`timescale 1ns / 1ps

module sorted_table_binary_search_top #(
  parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF,
  parameter int DATA_WIDTH  = stbs_pkg::DATA_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [stbs_pkg::CFG_W-1:0]       cfg_wr_data,  // entry_count
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [stbs_pkg::IN_TDATA_W-1:0]  in_tdata,     // write_index, entry_value, search_key
  input  logic                             in_tuser,     // req_type
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [stbs_pkg::OUT_TDATA_W-1:0] out_tdata,    // position
  output logic                             out_tuser     // found
);

  localparam int AW = $clog2(TABLE_DEPTH);

  logic                  mem_wr_en;
  logic [AW-1:0]         mem_wr_addr;
  logic [DATA_WIDTH-1:0] mem_wr_data;
  logic [AW-1:0]         mem_rd_addr;
  logic [DATA_WIDTH-1:0] mem_rd_data;

  stbs_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .mem_wr_en  (mem_wr_en),
    .mem_wr_addr(mem_wr_addr),
    .mem_wr_data(mem_wr_data),
    .mem_rd_addr(mem_rd_addr),
    .mem_rd_data(mem_rd_data)
  );

  stbs_mem #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk      (clk),
    .wr_en    (mem_wr_en),
    .wr_addr  (mem_wr_addr),
    .wr_data  (mem_wr_data),
    .rd_addr  (mem_rd_addr),
    .rd_data_r(mem_rd_data)
  );

endmodule

FILE: hdl/stbs_chk.sv
// Port checker for the sorted-table binary search block, bound to the top level.
// Depends on stbs_pkg and sorted_table_binary_search_top.
`timescale 1ns / 1ps

module stbs_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [stbs_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tuser
);

  a_rst_out_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  a_miss_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("miss carries a non-zero position");

  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == stbs_pkg::REQ_SEARCH |=> !in_tready)
    else $error("search word accepted without busy cycle");

  a_write_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == stbs_pkg::REQ_WRITE |=> in_tready)
    else $error("write word stalled the input");

endmodule

bind sorted_table_binary_search_top stbs_chk u_stbs_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tuser  (in_tuser),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);
